// ===== rtl/ppp_pkg.sv =====
// package with the phase, status and kind codes and the result struct of the publish parser
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

	// parse phases
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LEN     = 3'd1,
		PH_THI     = 3'd2,
		PH_TLO     = 3'd3,
		PH_TOPIC   = 3'd4,
		PH_PID     = 3'd5,
		PH_PAYLOAD = 3'd6
	} phase_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_PARSING  = 3'd0,
		ST_DONE     = 3'd1,
		ST_BAD_TYPE = 3'd2,
		ST_LEN_LONG = 3'd3,
		ST_SHORT    = 3'd4,
		ST_IDLE     = 3'd5
	} status_t;

	// byte classification
	typedef enum logic [1:0] {
		KIND_FRAME   = 2'd0,
		KIND_TOPIC   = 2'd1,
		KIND_PAYLOAD = 2'd2
	} kind_t;

	// accepted fixed headers
	localparam logic [7:0] HDR_QOS0 = 8'h30;
	localparam logic [7:0] HDR_QOS1 = 8'h32;
	localparam logic [7:0] HDR_QOS2 = 8'h34;

	// remaining length field coding
	localparam logic [7:0] LEN_DATA_MASK = 8'h7F;
	localparam logic [7:0] LEN_CONT_BIT  = 8'h80;

	localparam int LEN_W   = 28;
	localparam int TOPIC_W = 16;

	// one result item
	typedef struct packed {
		kind_t                kind;
		logic [7:0]           data;
		logic                 last;
		status_t              status;
		logic                 qos;
		logic [TOPIC_W-1:0]   topic_length;
		logic [LEN_W-1:0]     payload_length;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/ppp_parse_core.sv =====
// parse state registers and the per-item next state and result logic
`timescale 1ns / 1ps
`default_nettype none

module ppp_parse_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic [7:0]      data_byte,
	input  wire logic            packet_start,
	output ppp_pkg::result_t     result
);

	ppp_pkg::phase_t                 phase_q, phase_n;
	logic [ppp_pkg::LEN_W-1:0]       rem_q, rem_n;
	logic [1:0]                      lbc_q, lbc_n;
	logic                            qos_q, qos_n;
	logic [ppp_pkg::TOPIC_W-1:0]     topic_q, topic_n;
	logic [ppp_pkg::LEN_W-1:0]       left_q, left_n;
	logic [ppp_pkg::LEN_W-1:0]       plen_q, plen_n;

	logic [ppp_pkg::LEN_W-1:0]       len_group;
	logic [ppp_pkg::LEN_W-1:0]       rem_sum;
	logic [ppp_pkg::LEN_W-1:0]       left_dec;
	logic [ppp_pkg::LEN_W-1:0]       consumed;
	logic [ppp_pkg::TOPIC_W-1:0]     topic_full;
	logic [ppp_pkg::TOPIC_W:0]       vhl_tlo;
	logic [ppp_pkg::TOPIC_W:0]       vhl_cur;
	logic [ppp_pkg::TOPIC_W:0]       topic_end;
	logic [ppp_pkg::LEN_W:0]         tlo_diff;
	logic                            done;

	// shared arithmetic
	always_comb begin
		case (lbc_q)
			2'd0:    len_group = {20'd0, data_byte & ppp_pkg::LEN_DATA_MASK};
			2'd1:    len_group = {14'd0, data_byte[6:0], 7'd0};
			2'd2:    len_group = {7'd0, data_byte[6:0], 14'd0};
			default: len_group = {data_byte[6:0], 21'd0};
		endcase
		rem_sum    = rem_q + len_group;
		left_dec   = left_q - 28'd1;
		consumed   = rem_q - left_dec;
		topic_full = {topic_q[15:8], data_byte};
		vhl_tlo    = {1'b0, topic_full} + (qos_q ? 17'd4 : 17'd2);
		vhl_cur    = {1'b0, topic_q} + (qos_q ? 17'd4 : 17'd2);
		topic_end  = {1'b0, topic_q} + 17'd2;
		tlo_diff   = {1'b0, rem_q} - {12'd0, vhl_tlo};
	end

	// next state and result
	always_comb begin
		phase_n = phase_q;
		rem_n   = rem_q;
		lbc_n   = lbc_q;
		qos_n   = qos_q;
		topic_n = topic_q;
		left_n  = left_q;
		plen_n  = plen_q;
		done    = 1'b0;
		result.kind   = ppp_pkg::KIND_FRAME;
		result.data   = data_byte;
		result.last   = 1'b0;
		result.status = ppp_pkg::ST_PARSING;

		if (packet_start) begin
			rem_n   = '0;
			lbc_n   = '0;
			topic_n = '0;
			left_n  = '0;
			plen_n  = '0;
			if (data_byte == ppp_pkg::HDR_QOS0 || data_byte == ppp_pkg::HDR_QOS1 ||
					data_byte == ppp_pkg::HDR_QOS2) begin
				qos_n   = (data_byte != ppp_pkg::HDR_QOS0);
				phase_n = ppp_pkg::PH_LEN;
			end else begin
				qos_n         = 1'b0;
				phase_n       = ppp_pkg::PH_IDLE;
				result.status = ppp_pkg::ST_BAD_TYPE;
				result.last   = 1'b1;
			end
		end else begin
			case (phase_q)
				ppp_pkg::PH_LEN: begin
					rem_n = rem_sum;
					if ((data_byte & ppp_pkg::LEN_CONT_BIT) != 8'd0) begin
						if (lbc_q == 2'd3) begin
							phase_n       = ppp_pkg::PH_IDLE;
							result.status = ppp_pkg::ST_LEN_LONG;
							result.last   = 1'b1;
						end else begin
							lbc_n = lbc_q + 2'd1;
						end
					end else if (rem_sum < 28'd2) begin
						phase_n       = ppp_pkg::PH_IDLE;
						result.status = ppp_pkg::ST_SHORT;
						result.last   = 1'b1;
					end else begin
						left_n  = rem_sum;
						phase_n = ppp_pkg::PH_THI;
					end
				end
				ppp_pkg::PH_THI: begin
					topic_n = {data_byte, 8'd0};
					left_n  = left_dec;
					phase_n = ppp_pkg::PH_TLO;
				end
				ppp_pkg::PH_TLO: begin
					topic_n = topic_full;
					left_n  = left_dec;
					if (tlo_diff[ppp_pkg::LEN_W]) begin
						phase_n       = ppp_pkg::PH_IDLE;
						result.status = ppp_pkg::ST_SHORT;
						result.last   = 1'b1;
					end else begin
						plen_n = tlo_diff[ppp_pkg::LEN_W-1:0];
						if (left_dec == '0) begin
							done = 1'b1;
						end else if (topic_full != '0) begin
							phase_n = ppp_pkg::PH_TOPIC;
						end else begin
							phase_n = qos_q ? ppp_pkg::PH_PID : ppp_pkg::PH_PAYLOAD;
						end
					end
				end
				ppp_pkg::PH_TOPIC: begin
					result.kind = ppp_pkg::KIND_TOPIC;
					left_n      = left_dec;
					if (consumed == {11'd0, topic_end}) begin
						if (left_dec == '0) begin
							done = 1'b1;
						end else begin
							phase_n = qos_q ? ppp_pkg::PH_PID : ppp_pkg::PH_PAYLOAD;
						end
					end
				end
				ppp_pkg::PH_PID: begin
					left_n = left_dec;
					if (consumed == {11'd0, vhl_cur}) begin
						if (left_dec == '0) begin
							done = 1'b1;
						end else begin
							phase_n = ppp_pkg::PH_PAYLOAD;
						end
					end
				end
				ppp_pkg::PH_PAYLOAD: begin
					result.kind = ppp_pkg::KIND_PAYLOAD;
					left_n      = left_dec;
					if (left_dec == '0) begin
						done = 1'b1;
					end
				end
				default: begin
					phase_n       = ppp_pkg::PH_IDLE;
					result.status = ppp_pkg::ST_IDLE;
				end
			endcase
		end

		// packet complete
		if (done) begin
			phase_n       = ppp_pkg::PH_IDLE;
			result.status = ppp_pkg::ST_DONE;
			result.last   = 1'b1;
		end

		result.qos            = qos_n;
		result.topic_length   = topic_n;
		result.payload_length = plen_n;
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ppp_pkg::PH_IDLE;
			rem_q   <= '0;
			lbc_q   <= '0;
			qos_q   <= 1'b0;
			topic_q <= '0;
			left_q  <= '0;
			plen_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			rem_q   <= rem_n;
			lbc_q   <= lbc_n;
			qos_q   <= qos_n;
			topic_q <= topic_n;
			left_q  <= left_n;
			plen_q  <= plen_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/publish_packet_parser_top.sv =====
// top level of the publish packet parser: input register, parse core and result register
//
// Usage: packet bytes enter on the input channel (in_valid, in_stall, data_byte,
// packet_start), packet_start marking the first byte of each packet. Every
// accepted item produces exactly one result item on the output channel
// (out_valid, out_stall and the result fields), in order.
// An accepted item is held in the input register; the parse core computes its
// result combinationally, and the result register loads it when it can
// advance (it is empty or out_stall is low), which raises out_valid.
// Throughput: one item per cycle while out_stall is low; the parse state
// updates as an item moves from the input register to the result register.
// When the receiver raises out_stall the result register holds its item;
// an empty input register still takes one more item and then in_stall rises
// until the result is taken.
// Reset (arst_n low) empties both registers and returns the parser to idle
// with all lengths and the qos flag cleared.
`timescale 1ns / 1ps
`default_nettype none

module publish_packet_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        packet_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       byte_kind,
	output logic [7:0]       out_byte,
	output logic             last_of_packet,
	output logic [2:0]       status,
	output logic             qos_flag,
	output logic [15:0]      topic_length,
	output logic [27:0]      payload_length
);

	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               start_s1;
	logic               out_valid_q;
	ppp_pkg::result_t   result;
	ppp_pkg::result_t   result_q;
	logic               advance;
	logic               fire_s1;

	// handshake control
	assign advance  = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1  <= data_byte;
			start_s1 <= packet_start;
		end
	end

	// parse core
	ppp_parse_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire_s1),
		.data_byte    (data_s1),
		.packet_start (start_s1),
		.result       (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_q <= result;
		end
	end

	// output ports
	assign out_valid      = out_valid_q;
	assign byte_kind      = result_q.kind;
	assign out_byte       = result_q.data;
	assign last_of_packet = result_q.last;
	assign status         = result_q.status;
	assign qos_flag       = result_q.qos;
	assign topic_length   = result_q.topic_length;
	assign payload_length = result_q.payload_length;

endmodule

`default_nettype wire

// ===== tb/publish_packet_parser_top_test.sv =====
// testbench for the publish packet parser: directed and random byte streams checked against a predictor
`timescale 1ns / 1ps

module publish_packet_parser_top_test;

	localparam int unsigned LEN_MASK       = 32'h0FFF_FFFF;
	localparam int unsigned RANDOM_ITEMS   = 1300;
	localparam int unsigned RX_HOLD_CYCLES = 150;
	localparam int unsigned TAIL_CYCLES    = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        packet_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  byte_kind;
	logic [7:0]  out_byte;
	logic        last_of_packet;
	logic [2:0]  status;
	logic        qos_flag;
	logic [15:0] topic_length;
	logic [27:0] payload_length;

	publish_packet_parser_top DUT (.*);

	always #4 clk = ~clk;

	// parser state mirrored by the predictor
	ppp_pkg::phase_t m_phase = ppp_pkg::PH_IDLE;
	int unsigned m_rem = 0;
	int unsigned m_cnt = 0;
	logic        m_qos = 1'b0;
	logic [15:0] m_topic = '0;
	int unsigned m_left = 0;
	bit          m_hdr_ok = 1'b0;

	ppp_pkg::result_t parse_results[$];
	int unsigned items_parsed = 0;
	int unsigned mismatches = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	bit          hold_token = 1'b0;
	bit          hold_seen = 1'b0;
	int unsigned hold_left = 0;

	function automatic int unsigned var_header_len();
		return 32'(m_topic) + 32'd2 + (m_qos ? 32'd2 : 32'd0);
	endfunction

	function automatic ppp_pkg::phase_t phase_after_topic();
		if (m_qos)
			return ppp_pkg::PH_PID;
		return ppp_pkg::PH_PAYLOAD;
	endfunction

	// one parse step on an accepted byte, returns the predicted result item
	function automatic ppp_pkg::result_t parse_byte(input logic [7:0] b, input logic s);
		ppp_pkg::result_t r;
		bit      done;
		r = '0;
		r.kind = ppp_pkg::KIND_FRAME;
		r.status = ppp_pkg::ST_PARSING;
		r.data = b;
		done = 1'b0;
		if (s) begin
			m_rem = 0;
			m_cnt = 0;
			m_topic = '0;
			m_left = 0;
			m_hdr_ok = 1'b0;
			if (b == ppp_pkg::HDR_QOS0 || b == ppp_pkg::HDR_QOS1 ||
					b == ppp_pkg::HDR_QOS2) begin
				m_qos = (b != ppp_pkg::HDR_QOS0);
				m_phase = ppp_pkg::PH_LEN;
			end else begin
				m_qos = 1'b0;
				m_phase = ppp_pkg::PH_IDLE;
				r.status = ppp_pkg::ST_BAD_TYPE;
				r.last = 1'b1;
			end
		end else begin
			case (m_phase)
				ppp_pkg::PH_LEN: begin
					m_rem = (m_rem + (32'(b & ppp_pkg::LEN_DATA_MASK) << (7 * m_cnt)))
						& LEN_MASK;
					if ((b & ppp_pkg::LEN_CONT_BIT) != 0) begin
						if (m_cnt >= 3) begin
							m_phase = ppp_pkg::PH_IDLE;
							r.status = ppp_pkg::ST_LEN_LONG;
							r.last = 1'b1;
						end else begin
							m_cnt++;
						end
					end else if (m_rem < 2) begin
						m_phase = ppp_pkg::PH_IDLE;
						r.status = ppp_pkg::ST_SHORT;
						r.last = 1'b1;
					end else begin
						m_left = m_rem;
						m_phase = ppp_pkg::PH_THI;
					end
				end
				ppp_pkg::PH_THI: begin
					m_topic = {b, 8'h00};
					m_left--;
					m_phase = ppp_pkg::PH_TLO;
				end
				ppp_pkg::PH_TLO: begin
					m_topic[7:0] = b;
					m_left--;
					if (m_rem < var_header_len()) begin
						m_phase = ppp_pkg::PH_IDLE;
						r.status = ppp_pkg::ST_SHORT;
						r.last = 1'b1;
					end else begin
						m_hdr_ok = 1'b1;
						if (m_left == 0)
							done = 1'b1;
						else if (m_topic != 0)
							m_phase = ppp_pkg::PH_TOPIC;
						else
							m_phase = phase_after_topic();
					end
				end
				ppp_pkg::PH_TOPIC: begin
					r.kind = ppp_pkg::KIND_TOPIC;
					m_left--;
					if (m_rem - m_left == 32'(m_topic) + 32'd2) begin
						if (m_left == 0)
							done = 1'b1;
						else
							m_phase = phase_after_topic();
					end
				end
				ppp_pkg::PH_PID: begin
					m_left--;
					if (m_rem - m_left == var_header_len()) begin
						if (m_left == 0)
							done = 1'b1;
						else
							m_phase = ppp_pkg::PH_PAYLOAD;
					end
				end
				ppp_pkg::PH_PAYLOAD: begin
					r.kind = ppp_pkg::KIND_PAYLOAD;
					m_left--;
					if (m_left == 0)
						done = 1'b1;
				end
				default: begin
					m_phase = ppp_pkg::PH_IDLE;
					r.status = ppp_pkg::ST_IDLE;
				end
			endcase
		end
		if (done) begin
			m_phase = ppp_pkg::PH_IDLE;
			r.status = ppp_pkg::ST_DONE;
			r.last = 1'b1;
		end
		r.qos = m_qos;
		r.topic_length = m_topic;
		r.payload_length = m_hdr_ok ? ppp_pkg::LEN_W'(m_rem - var_header_len()) : '0;
		return r;
	endfunction

	function automatic logic [7:0] pick_header();
		case ($urandom_range(2))
			0: return ppp_pkg::HDR_QOS0;
			1: return ppp_pkg::HDR_QOS1;
			default: return ppp_pkg::HDR_QOS2;
		endcase
	endfunction

	// offer one item, hold it until taken, then predict its result
	task automatic send_byte(input logic [7:0] b, input logic s);
		if (tx_idle_on && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		packet_start <= s;
		do @(posedge clk); while (in_stall);
		items_parsed++;
		parse_results.push_back(parse_byte(b, s));
	endtask

	// header, remaining length field with optional zero groups, then nsend bytes
	// of which the first two are the topic length
	task automatic send_packet(input logic [7:0] hdr, input int unsigned rem, input int pad,
			input logic [15:0] tlen, input int unsigned nsend);
		logic [7:0]  lenq[$];
		int unsigned v;
		v = rem;
		do begin
			lenq.push_back(8'(v[6:0]));
			v = v >> 7;
		end while (v != 0);
		repeat (pad) lenq.push_back(8'h00);
		for (int i = 0; i < lenq.size() - 1; i++)
			lenq[i][7] = 1'b1;
		send_byte(hdr, 1'b1);
		foreach (lenq[i])
			send_byte(lenq[i], 1'b0);
		for (int unsigned i = 0; i < nsend; i++) begin
			if (i == 0)
				send_byte(tlen[15:8], 1'b0);
			else if (i == 1)
				send_byte(tlen[7:0], 1'b0);
			else
				send_byte(8'($urandom_range(255)), 1'b0);
		end
	endtask

	// well-formed publish with random content, now and then cut short or overrun
	task automatic send_random_publish();
		logic [7:0]  hdr;
		int unsigned tlen;
		int unsigned rem;
		int unsigned nsend;
		int unsigned cut;
		int          pad;
		hdr = pick_header();
		tlen = $urandom_range(0, 8);
		rem = tlen + 2 + ((hdr != ppp_pkg::HDR_QOS0) ? 2 : 0) + $urandom_range(0, 12);
		pad = ($urandom_range(99) < 15) ? $urandom_range(0, 3) : 0;
		cut = $urandom_range(99);
		if (cut < 8)
			nsend = $urandom_range(0, rem);
		else if (cut < 12)
			nsend = rem + $urandom_range(1, 3);
		else
			nsend = rem;
		send_packet(hdr, rem, pad, 16'(tlen), nsend);
	endtask

	// stop offering and wait for every predicted result
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (parse_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// receiver: check each taken result, then decide the next stall
	always @(posedge clk) begin
		ppp_pkg::result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (parse_results.size() == 0) begin
					$error("result item with no prediction pending, out_byte %0d", out_byte);
					mismatches++;
				end else begin
					e = parse_results.pop_front();
					check_field("byte_kind", e.kind, byte_kind);
					check_field("out_byte", e.data, out_byte);
					check_field("last_of_packet", e.last, last_of_packet);
					check_field("status", e.status, status);
					check_field("qos_flag", e.qos, qos_flag);
					check_field("topic_length", e.topic_length, topic_length);
					check_field("payload_length", e.payload_length, payload_length);
				end
			end
			if (hold_token != hold_seen) begin
				hold_seen <= hold_token;
				hold_left <= RX_HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= rx_idle_on && ($urandom_range(99) < 22);
			end
		end
	end

	// field extremes, every header and each error and end condition
	task automatic test_directed();
		send_byte(8'hFF, 1'b0);                       // byte while idle
		send_byte(8'h31, 1'b1);                       // bad type
		send_byte(8'hFF, 1'b1);
		send_packet(ppp_pkg::HDR_QOS0, 2, 0, 16'd0, 2);   // ends in variable header
		send_packet(ppp_pkg::HDR_QOS1, 4, 0, 16'd0, 4);   // packet id only
		send_packet(ppp_pkg::HDR_QOS2, 9, 0, 16'd3, 9);   // topic, id and payload
		send_packet(ppp_pkg::HDR_QOS0, 1, 0, 16'd0, 0);   // whole header too short
		send_packet(ppp_pkg::HDR_QOS0, 4, 0, 16'd5, 2);   // topic overruns remaining length
		send_packet(ppp_pkg::HDR_QOS1, 3, 0, 16'd0, 2);   // no room for packet id
		send_byte(ppp_pkg::HDR_QOS0, 1'b1);               // length field too long
		repeat (4) send_byte(8'hFF, 1'b0);
		send_packet(ppp_pkg::HDR_QOS0, 5, 3, 16'd1, 5);   // four-byte length field that ends
		// largest lengths, then restart
		send_packet(ppp_pkg::HDR_QOS2, LEN_MASK, 0, 16'hFFFF, 3);
		send_packet(ppp_pkg::HDR_QOS0, 4, 0, 16'd1, 5);   // trailing byte after done
		wait_drained();
	endtask

	// back-to-back traffic with no idling on either side
	task automatic test_streaming();
		tx_idle_on = 1'b0;
		rx_idle_on <= 1'b0;
		repeat (20) send_random_publish();
		wait_drained();
		tx_idle_on = 1'b1;
		rx_idle_on <= 1'b1;
	endtask

	// receiver holds off while items keep coming, then the sender waits for all results
	task automatic test_backpressure();
		hold_token <= ~hold_token;
		repeat (5) send_random_publish();
		wait_drained();
	endtask

	// mostly well-formed packets, plus broken ones and noise
	task automatic test_random_traffic();
		int unsigned first;
		int unsigned pick;
		first = items_parsed;
		while (items_parsed - first < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_random_publish();
			end else if (pick < 80) begin
				// huge remaining length, abandoned early
				send_packet(pick_header(), $urandom_range(LEN_MASK, 2), 0,
					16'($urandom_range(16'hFFFF)), $urandom_range(0, 8));
			end else if (pick < 88) begin
				send_packet(pick_header(), $urandom_range(0, 6), $urandom_range(0, 1),
					16'($urandom_range(0, 6)), $urandom_range(0, 8));
			end else if (pick < 93) begin
				send_packet(8'($urandom_range(255)), $urandom_range(2, 10), 0,
					16'($urandom_range(0, 3)), $urandom_range(0, 4));
			end else if (pick < 96) begin
				send_byte(pick_header(), 1'b1);
				repeat ($urandom_range(4, 6))
					send_byte(8'h80 | 8'($urandom_range(127)), 1'b0);
			end else begin
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(255)), 1'b0);
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_streaming();
		test_backpressure();
		test_random_traffic();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && parse_results.size() == 0)
			$display("publish_packet_parser_top test passed");
		else
			$display("publish_packet_parser_top test failed");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("publish_packet_parser_top test failed");
		$finish;
	end

endmodule
